// ===== rtl/core/bpa_pkg.sv =====
// Shared types and constants for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  // Wide enough for any page index, buddy or region size the parameters allow
  localparam int WIDE_W = 17;
  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    FN_REBUILD = 3'd0,
    FN_ALLOC   = 3'd1,
    FN_FREE    = 3'd2,
    FN_INCREF  = 3'd3,
    FN_DECREF  = 3'd4,
    FN_GETREF  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOMEM      = 3'd1,
    ST_BADPAGE    = 3'd2,
    ST_UNDERFLOW  = 3'd3,
    ST_REFERENCED = 3'd4
  } status_e;

  // Classified request handed from front to back
  typedef struct packed {
    func_e       func;
    logic [14:0] page;
    logic [3:0]  order;
    logic        page_ok;
  } cmd_t;

  // One result
  typedef struct packed {
    status_e     status;
    logic [14:0] out_page;
    logic [7:0]  count;
    logic        unref;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bpa_front.sv =====
// Front end: takes stream requests, decodes the function and checks the page range.
`default_nettype none
module bpa_front import bpa_pkg::*; #(
  parameter int NW = 16
) (
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [2:0]    func_i,
  input  wire logic [14:0]   page_i,
  input  wire logic [3:0]    order_i,
  input  wire logic [NW-1:0] n_i,
  input  wire logic          init_busy_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  // Hold off while the queue is full or the memories are being cleared
  assign s_ready_o = !q_full_i && !init_busy_i;
  assign push_o    = s_valid_i && s_ready_o;

  // Classify the request
  always_comb begin
    cmd_o.func    = func_e'(func_i);
    cmd_o.page    = page_i;
    cmd_o.order   = order_i;
    cmd_o.page_ok = WIDE_W'(page_i) < WIDE_W'(n_i);
  end

endmodule
`default_nettype wire

// ===== rtl/core/bpa_queue.sv =====
// Short request queue between the front end and the engine.
`default_nettype none
module bpa_queue import bpa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t           slot_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PW:0]    fill_q;

  assign full_o  = fill_q == (PW+1)'(QUEUE_DEPTH);
  assign valid_o = fill_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      fill_q <= fill_q + (PW+1)'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bpa_engine.sv =====
// Back end: sequencer over the free-mark, reference-count and order memories.
`default_nettype none
module bpa_engine import bpa_pkg::*; #(
  parameter int PAGES     = 32768,
  parameter int TOP_ORDER = 10,
  parameter int NW        = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire cmd_t          cmd_i,
  output logic               cmd_pop_o,
  input  wire logic [NW-1:0] n_i,
  output logic               init_busy_o,
  output logic               res_valid_o,
  output res_t               res_o,
  input  wire logic          res_ready_i
);

  localparam int AW = $clog2(PAGES);
  localparam int MW = TOP_ORDER + 1;
  localparam int KW = 5;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SWEEP, S_REF, S_SCAN, S_TAKE_RD, S_TAKE_WR,
    S_SPLIT_RD, S_SPLIT_WR, S_MERGE_RD, S_MERGE_CHK, S_MARK_RD,
    S_MARK_WR, S_ORD_CLR, S_DONE
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [WIDE_W-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]       p_q, p_d;
  logic [3:0]          k_q, k_d;
  logic [KW-1:0]       best_k_q, best_k_d;
  logic [AW-1:0]       best_p_q, best_p_d;
  logic                scan_vld_q, scan_vld_d;
  logic [NW-1:0]       n_q, n_d;
  logic [3:0]          rb_k_q, rb_k_d;
  res_t                res_q, res_d;
  res_t                out_q;
  logic                out_vld_q;

  // Memory ports
  logic [MW-1:0] mk_mem [PAGES];
  logic [7:0]    rf_mem [PAGES];
  logic [3:0]    od_mem [PAGES];
  logic [AW-1:0] mk_addr, rf_addr, od_addr;
  logic          mk_we, rf_we, od_we;
  logic [MW-1:0] mk_wdata, mk_rdata_q;
  logic [7:0]    rf_wdata, rf_rdata_q;
  logic [3:0]    od_wdata, od_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mk_we) mk_mem[mk_addr] <= mk_wdata;
    mk_rdata_q <= mk_mem[mk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_addr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_addr];
  end

  always_ff @(posedge clk_i) begin
    if (od_we) od_mem[od_addr] <= od_wdata;
    od_rdata_q <= od_mem[od_addr];
  end

  // Derived values
  logic [WIDE_W-1:0] wide_p, buddy, buddy_up, buddy_sp, clr_addr;
  logic [WIDE_W-1:0] sw_mask, cur_end;
  logic [MW-1:0]     bit_k, sweep_mark, scan_mask, scan_hit;
  logic [KW-1:0]     scan_k;
  logic [3:0]        rb_k_calc, k_dn;
  logic [7:0]        rc;

  always_comb begin
    wide_p   = WIDE_W'(p_q);
    buddy    = wide_p ^ (WIDE_W'(1) << k_q);
    k_dn     = k_q - 4'd1;
    buddy_up = WIDE_W'(best_p_q) ^ (WIDE_W'(1) << k_dn);
    buddy_sp = WIDE_W'(best_p_q) ^ (WIDE_W'(1) << k_q);
    clr_addr = wide_p + cnt_q;
    bit_k    = MW'(1) << k_q;
    rc       = rf_rdata_q;

    // Rebuild pattern for the page under the sweep counter; pages inside a block stay clear
    sw_mask = (WIDE_W'(1) << rb_k_q) - WIDE_W'(1);
    cur_end = WIDE_W'(n_q) & ~sw_mask;
    if (cnt_q < cur_end) begin
      sweep_mark = ((cnt_q & sw_mask) == '0) ? (MW'(1) << rb_k_q) : '0;
    end else if (cnt_q < WIDE_W'(n_q)) begin
      sweep_mark = MW'(1);
    end else begin
      sweep_mark = '0;
    end

    // Largest order that fits the region
    rb_k_calc = '0;
    for (int j = 1; j <= TOP_ORDER; j++) begin
      if ((WIDE_W'(1) << j) <= WIDE_W'(n_i)) rb_k_calc = 4'(j);
    end

    // Lowest usable order in the marks just read
    scan_mask = ~((MW'(1) << cmd_q.order) - MW'(1));
    scan_hit  = mk_rdata_q & scan_mask;
    scan_k    = KW'(MW);
    for (int j = MW - 1; j >= 0; j--) begin
      if (scan_hit[j]) scan_k = KW'(j);
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    k_d        = k_q;
    best_k_d   = best_k_q;
    best_p_d   = best_p_q;
    scan_vld_d = 1'b0;
    n_d        = n_q;
    rb_k_d     = rb_k_q;
    res_d      = res_q;
    cmd_pop_o  = 1'b0;
    mk_addr    = p_q;
    rf_addr    = AW'(cmd_q.page);
    od_addr    = AW'(cmd_q.page);
    mk_we      = 1'b0;
    rf_we      = 1'b0;
    od_we      = 1'b0;
    mk_wdata   = mk_rdata_q;
    rf_wdata   = rc;
    od_wdata   = '0;

    unique case (state_q)
      S_INIT, S_SWEEP: begin
        mk_addr  = cnt_q[AW-1:0];
        rf_addr  = cnt_q[AW-1:0];
        od_addr  = cnt_q[AW-1:0];
        mk_we    = 1'b1;
        rf_we    = 1'b1;
        od_we    = 1'b1;
        mk_wdata = sweep_mark;
        rf_wdata = '0;
        cnt_d    = cnt_q + WIDE_W'(1);
        if (cnt_q == WIDE_W'(PAGES - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end

      S_IDLE: begin
        rf_addr = AW'(cmd_i.page);
        od_addr = AW'(cmd_i.page);
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          n_d       = n_i;
          cnt_d     = '0;
          case (cmd_i.func)
            FN_REBUILD: begin
              rb_k_d  = rb_k_calc;
              state_d = S_SWEEP;
            end
            FN_ALLOC: begin
              if (cmd_i.order > 4'(TOP_ORDER)) begin
                res_d.status = ST_NOMEM;
                state_d      = S_DONE;
              end else begin
                best_k_d = KW'(MW);
                state_d  = S_SCAN;
              end
            end
            FN_FREE, FN_INCREF, FN_DECREF, FN_GETREF: begin
              if (!cmd_i.page_ok) begin
                res_d.status = ST_BADPAGE;
                state_d      = S_DONE;
              end else begin
                state_d = S_REF;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_REF: begin
        state_d = S_DONE;
        case (cmd_q.func)
          FN_INCREF: begin
            rf_we       = 1'b1;
            rf_wdata    = (rc < COUNT_MAX) ? rc + 8'd1 : rc;
            res_d.count = rf_wdata;
          end
          FN_DECREF: begin
            if (rc == '0) begin
              res_d.status = ST_UNDERFLOW;
            end else begin
              rf_we       = 1'b1;
              rf_wdata    = rc - 8'd1;
              res_d.count = rf_wdata;
              res_d.unref = rc == 8'd1;
            end
          end
          FN_GETREF: res_d.count = rc;
          FN_FREE: begin
            if (rc != '0) begin
              res_d.status = ST_REFERENCED;
              res_d.count  = rc;
            end else begin
              p_d     = AW'(cmd_q.page);
              k_d     = (od_rdata_q > 4'(TOP_ORDER)) ? 4'(TOP_ORDER) : od_rdata_q;
              state_d = S_MERGE_RD;
            end
          end
          default: ;
        endcase
      end

      // Lowest address among the smallest usable order; reads are pipelined
      S_SCAN: begin
        mk_addr = cnt_q[AW-1:0];
        if (cnt_q < WIDE_W'(PAGES)) begin
          scan_vld_d = 1'b1;
          cnt_d      = cnt_q + WIDE_W'(1);
        end
        if (scan_vld_q && scan_hit != '0 && scan_k < best_k_q) begin
          best_k_d = scan_k;
          best_p_d = AW'(cnt_q - WIDE_W'(1));
          if (scan_k == KW'(cmd_q.order)) state_d = S_TAKE_RD;
        end else if (!scan_vld_q && cnt_q == WIDE_W'(PAGES)) begin
          if (best_k_q == KW'(MW)) begin
            res_d.status = ST_NOMEM;
            state_d      = S_DONE;
          end else begin
            state_d = S_TAKE_RD;
          end
        end
      end

      S_TAKE_RD: begin
        mk_addr = best_p_q;
        state_d = S_TAKE_WR;
      end

      S_TAKE_WR: begin
        mk_addr        = best_p_q;
        rf_addr        = best_p_q;
        od_addr        = best_p_q;
        mk_we          = 1'b1;
        rf_we          = 1'b1;
        od_we          = 1'b1;
        mk_wdata       = mk_rdata_q & ~(MW'(1) << best_k_q);
        rf_wdata       = 8'd1;
        od_wdata       = cmd_q.order;
        res_d.out_page = 15'(best_p_q);
        res_d.count    = 8'd1;
        k_d            = best_k_q[3:0];
        state_d        = S_SPLIT_RD;
      end

      // Hand the upper halves back as free buddies
      S_SPLIT_RD: begin
        if (k_q > cmd_q.order) begin
          k_d = k_dn;
          if (buddy_up < WIDE_W'(PAGES)) begin
            mk_addr = buddy_up[AW-1:0];
            state_d = S_SPLIT_WR;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_SPLIT_WR: begin
        mk_addr  = buddy_sp[AW-1:0];
        mk_we    = 1'b1;
        mk_wdata = mk_rdata_q | bit_k;
        state_d  = S_SPLIT_RD;
      end

      // Merge upward while the buddy is free at the same order
      S_MERGE_RD: begin
        if (k_q >= 4'(TOP_ORDER) || buddy >= WIDE_W'(n_q)) begin
          state_d = S_MARK_RD;
        end else begin
          mk_addr = buddy[AW-1:0];
          state_d = S_MERGE_CHK;
        end
      end

      S_MERGE_CHK: begin
        mk_addr = buddy[AW-1:0];
        if ((mk_rdata_q & bit_k) == '0) begin
          state_d = S_MARK_RD;
        end else begin
          mk_we    = 1'b1;
          mk_wdata = mk_rdata_q & ~bit_k;
          if (buddy < wide_p) p_d = buddy[AW-1:0];
          k_d     = k_q + 4'd1;
          state_d = S_MERGE_RD;
        end
      end

      S_MARK_RD: state_d = S_MARK_WR;

      S_MARK_WR: begin
        mk_we    = 1'b1;
        mk_wdata = mk_rdata_q | bit_k;
        cnt_d    = '0;
        state_d  = S_ORD_CLR;
      end

      // Clear the recorded order over the merged block
      S_ORD_CLR: begin
        od_addr  = clr_addr[AW-1:0];
        od_we    = 1'b1;
        od_wdata = '0;
        cnt_d    = cnt_q + WIDE_W'(1);
        if (cnt_q == (WIDE_W'(1) << k_q) - WIDE_W'(1) ||
            clr_addr == WIDE_W'(PAGES - 1)) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      n_q        <= '0;
      rb_k_q     <= '0;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
      rb_k_q     <= rb_k_d;
      scan_vld_q <= scan_vld_d;
      if (state_q == S_DONE && (!out_vld_q || res_ready_i)) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    p_q      <= p_d;
    k_q      <= k_d;
    best_k_q <= best_k_d;
    best_p_q <= best_p_d;
    res_q    <= res_d;
    if (state_q == S_DONE && (!out_vld_q || res_ready_i)) out_q <= res_q;
  end

  assign init_busy_o = state_q == S_INIT;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // Checks
  a_no_pop_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !cmd_pop_o)
    else $error("request taken during memory clear");

  a_nomem_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == ST_NOMEM |-> out_q.out_page == '0 && out_q.count == '0)
    else $error("failed alloc carries payload");

  a_unref_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.unref |-> out_q.count == '0 && out_q.status == ST_OK)
    else $error("unreferenced flag with nonzero count");

  a_one_write_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !mk_we && !rf_we && !od_we)
    else $error("memory written during alloc search");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_vld_q |=> state_q == S_IDLE && out_vld_q)
    else $error("result not posted");

endmodule
`default_nettype wire

// ===== rtl/core/buddy_page_allocator_refcount.sv =====
// Top level: buddy page allocator with per-page reference counts.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser=func, tdata=page,block_order
//  m_axis    out  m_axis_tvalid/tready      tuser=status, tdata=out_page,count,unref
//  apb       in   psel&penable&pwrite       paddr[2]=0: num_pages
//
// One request at a time in the engine; two more wait in the queue.
// Ref ops read and update the count; free then merges upward and clears the block's order.
// Alloc scans the free-mark memory at one page a cycle, then splits off the upper halves.
// Rebuild and the clear after reset sweep all PAGES entries, one per cycle;
// no request is taken during the clear after reset.
// A waiting result holds the engine; the queue keeps taking requests until full.
`default_nettype none
module buddy_page_allocator_refcount import bpa_pkg::*; #(
  parameter int PAGES     = 32768,
  parameter int TOP_ORDER = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // page[14:0], block_order[18:15], zero pad
  input  wire logic [2:0]  s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // out_page[14:0], count_now[22:15], now_unref[23]
  output logic [2:0]       m_axis_tuser,   // status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(PAGES);
  localparam int NW = AW + 1;

  logic [15:0]   num_pages_q;
  logic [NW-1:0] n_eff;
  logic          q_full, push, pop, q_valid, init_busy;
  cmd_t          cmd_in, cmd_head;
  res_t          res;

  // Config register
  assign pready = 1'b1;
  assign prdata = {16'b0, num_pages_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pages_q <= 16'd32768;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      num_pages_q <= pwdata[15:0];
    end
  end

  // Region size saturated to the memory depth
  assign n_eff = (WIDE_W'(num_pages_q) > WIDE_W'(PAGES)) ? NW'(PAGES) : NW'(num_pages_q);

  bpa_front #(.NW(NW)) u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .func_i      (s_axis_tuser),
    .page_i      (s_axis_tdata[14:0]),
    .order_i     (s_axis_tdata[18:15]),
    .n_i         (n_eff),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  bpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_head)
  );

  bpa_engine #(.PAGES(PAGES), .TOP_ORDER(TOP_ORDER), .NW(NW)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (pop),
    .n_i         (n_eff),
    .init_busy_o (init_busy),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {res.unref, res.count, res.out_page};

endmodule
`default_nettype wire
